// ===== sv/luc_pkg.sv =====
// Shared types, constants and round functions for the 128-bit Lucifer block cipher.
// Used by luc_round, lucifer_block_cipher, lucifer_block_checker and testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package luc_pkg;

    localparam int NUM_ROUNDS = 16;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(1);

    localparam logic [3:0] SBOX_A [16] = '{
        4'hC, 4'hF, 4'h7, 4'hA, 4'hE, 4'hD, 4'hB, 4'h0,
        4'h2, 4'h6, 4'h3, 4'h1, 4'h9, 4'h4, 4'h5, 4'h8
    };

    localparam logic [3:0] SBOX_B [16] = '{
        4'h7, 4'h2, 4'hE, 4'h9, 4'h3, 4'hB, 4'h0, 4'h4,
        4'hC, 4'hD, 4'h1, 4'hA, 4'h6, 4'hF, 4'h8, 4'h5
    };

    localparam logic [2:0] SPREAD_OFS [8] = '{
        3'd7, 3'd6, 3'd2, 3'd1, 3'd5, 3'd0, 3'd3, 3'd4
    };

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic        decrypt;
    } request_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
    } response_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] up;
        logic        dec;
    } stage_t;

    function automatic logic [7:0] luc_permute(input logic [7:0] v);
        return {v[5], v[2], v[3], v[7], v[4], v[6], v[0], v[1]};
    endfunction

    // Mask that one round XORs into the lower half, computed from the upper half.
    function automatic logic [63:0] luc_mix(
        input logic [63:0]  up,
        input logic [127:0] key,
        input logic [3:0]   base
    );
        logic [63:0] mask;
        logic [7:0]  ctrl;
        logic [7:0]  m;
        logic [7:0]  byte_in;
        logic [3:0]  kidx;
        logic [2:0]  t;
        mask = '0;
        ctrl = key[8*base +: 8];
        for (int j = 0; j < 8; j++) begin
            byte_in = up[8*j +: 8];
            if (ctrl[j]) begin
                m = {SBOX_B[byte_in[7:4]], SBOX_A[byte_in[3:0]]};
            end
            else begin
                m = {SBOX_A[byte_in[7:4]], SBOX_B[byte_in[3:0]]};
            end
            kidx = base + 4'(j);
            m = luc_permute(m ^ key[8*kidx +: 8]);
            for (int b = 0; b < 8; b++) begin
                t = SPREAD_OFS[b] + 3'(j);
                mask[8*t + (7-b)] = mask[8*t + (7-b)] ^ m[7-b];
            end
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== sv/luc_round.sv =====
// One Lucifer round cell: applies a single round to the incoming block and registers the result for the next cell.
// Depends on luc_pkg for the stage type and the round mixing function.
`timescale 1ns / 1ps
`default_nettype none

module luc_round
    import luc_pkg::*;
#(
    parameter int ROUND = 0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic [127:0] key,
    input  wire logic         prev_valid,
    input  wire stage_t       prev_stage,
    output logic              cell_valid,
    output stage_t            cell_stage
);

    localparam logic [3:0] ENC_BASE = 4'((7 * ROUND) % 16);
    localparam logic [3:0] DEC_BASE = 4'((9 + 9 * ROUND) % 16);

    logic        valid_reg;
    logic        valid_next;
    stage_t      stage_reg;
    stage_t      stage_next;
    logic [3:0]  base;

    always_comb
    begin
        base             = prev_stage.dec ? DEC_BASE : ENC_BASE;
        stage_next.dec   = prev_stage.dec;
        stage_next.lo    = prev_stage.up;
        stage_next.up    = prev_stage.lo ^ luc_mix(prev_stage.up, key, base);
        valid_next       = prev_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_stage = stage_reg;

endmodule

`default_nettype wire

// ===== sv/lucifer_block_cipher.sv =====
// Top level of the 128-bit Lucifer cipher: key registers and a chain of sixteen round cells.
// Depends on luc_pkg and luc_round.
//
//  Channel  Signals                          Direction  Meaning
//  block    block_valid, block_stall, block  in         one block to encrypt or decrypt
//  result   result_valid, result_stall, result out      the processed block
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  in  key register writes
//
// A block passes through the round cells in order, one round per cell, and leaves from the last cell.
// A new block can enter every cycle while block_stall is low; the chain of round cells sets that rate.
// Reset clears both key registers and all stage valid flags.
// While a result waits and result_stall is high, the whole chain holds and block_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module lucifer_block_cipher
    import luc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 block_valid,
    output logic                      block_stall,
    input  wire request_t             block,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output response_t                 result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic        en;
    logic        vld [NUM_ROUNDS+1];
    stage_t      stg [NUM_ROUNDS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_KEY_LOW)
            begin
                key_low_reg <= cfg_data;
            end
            else if (cfg_index == CFG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
        end
    end

    assign en          = !vld[NUM_ROUNDS] || !result_stall;
    assign block_stall = !en;

    assign vld[0]     = block_valid;
    assign stg[0].lo  = block.block_low;
    assign stg[0].up  = block.block_high;
    assign stg[0].dec = block.decrypt;

    for (genvar r = 0; r < NUM_ROUNDS; r++)
    begin : g_round
        luc_round #(
            .ROUND (r)
        ) u_round (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .key        ({key_high_reg, key_low_reg}),
            .prev_valid (vld[r]),
            .prev_stage (stg[r]),
            .cell_valid (vld[r+1]),
            .cell_stage (stg[r+1])
        );
    end

    // The final swap undoes the last round's swap.
    assign result_valid       = vld[NUM_ROUNDS];
    assign result.result_low  = stg[NUM_ROUNDS].up;
    assign result.result_high = stg[NUM_ROUNDS].lo;

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> block_stall)
        else $error("waiting result did not stall the input");

    a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !block_stall)
        else $error("input stalled with no result waiting");

    a_enter_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (block_valid && !block_stall) |=> vld[1])
        else $error("accepted request did not enter the first round cell");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== tb/lucifer_block_checker.sv =====
// Checker for the 128-bit Lucifer cipher: watches the block, result and key write channels.
// Predicts every processed block from its own copy of the key and compares it with the result.
// Depends on luc_pkg for the request, response and register index definitions.
`timescale 1ns / 1ps

module lucifer_block_checker
    import luc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 block_valid,
    input  logic                 block_stall,
    input  request_t             block,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  response_t            result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);

    localparam int          ROUNDS   = 16;
    localparam logic [63:0] NIB_A    = 64'h854913620BDEA7FC;
    localparam logic [63:0] NIB_B    = 64'h58F6A1DC40B39E27;
    localparam logic [23:0] FAN_OUT  = 24'h8C52B7;

    logic [127:0] cipher_key;
    response_t    expected_blocks [$];
    response_t    want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic response_t lucifer_crypt(input request_t req, input logic [127:0] key);
        logic [63:0] lo;
        logic [63:0] up;
        logic [63:0] swap;
        logic [7:0]  ctrl;
        logic [7:0]  m;
        logic [7:0]  p;
        logic [3:0]  base;
        logic [3:0]  kidx;
        logic [2:0]  t;
        response_t   res;
        lo   = req.block_low;
        up   = req.block_high;
        base = req.decrypt ? 4'd9 : 4'd0;
        for (int r = 0; r < ROUNDS; r++)
        begin
            ctrl = key[8*base +: 8];
            for (int j = 0; j < 8; j++)
            begin
                m = up[8*j +: 8];
                if (ctrl[j])
                begin
                    m = {NIB_B[4*m[7:4] +: 4], NIB_A[4*m[3:0] +: 4]};
                end
                else
                begin
                    m = {NIB_A[4*m[7:4] +: 4], NIB_B[4*m[3:0] +: 4]};
                end
                kidx = base + 4'(j);
                m    = m ^ key[8*kidx +: 8];
                p    = {m[5], m[2], m[3], m[7], m[4], m[6], m[0], m[1]};
                for (int b = 0; b < 8; b++)
                begin
                    t = FAN_OUT[3*b +: 3] + 3'(j);
                    lo[8*t + 7 - b] = lo[8*t + 7 - b] ^ p[7-b];
                end
            end
            base = base + (req.decrypt ? 4'd9 : 4'd7);
            swap = lo;
            lo   = up;
            up   = swap;
        end
        res.result_low  = up;
        res.result_high = lo;
        return res;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key = '0;
            expected_blocks.delete();
            pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    report($sformatf("result %h_%h arrived with no request pending",
                                     result.result_high, result.result_low));
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (result.result_low !== want.result_low)
                    begin
                        report($sformatf("result_low %h, expected %h",
                                         result.result_low, want.result_low));
                    end
                    if (result.result_high !== want.result_high)
                    begin
                        report($sformatf("result_high %h, expected %h",
                                         result.result_high, want.result_high));
                    end
                end
            end
            if (block_valid && !block_stall)
            begin
                expected_blocks.push_back(lucifer_crypt(block, cipher_key));
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_KEY_LOW)
                begin
                    cipher_key[63:0] = cfg_data;
                end
                else if (cfg_index == CFG_KEY_HIGH)
                begin
                    cipher_key[127:64] = cfg_data;
                end
            end
            pending = expected_blocks.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the Lucifer cipher testbench: clock, reset, key writes, block requests and result stalls.
// Instantiates lucifer_block_cipher and lucifer_block_checker; depends on luc_pkg.
`timescale 1ns / 1ps

module testbench;

    import luc_pkg::*;

    localparam int LATENCY       = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 80;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 block_valid  = 1'b0;
    logic                 block_stall;
    request_t             block        = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    response_t            result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [63:0]          cfg_data     = '0;
    int                   fail_count;
    int                   pending;

    int       cycle_count  = 0;
    int       burst_left   = 0;
    int       gap_max      = 8;
    int       holds_asked  = 0;
    int       holds_done   = 0;
    int       hold_left    = 0;
    int       mode_left    = 0;
    rx_mode_t rx_mode      = RX_FREE;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lucifer_block_cipher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .block_valid  (block_valid),
        .block_stall  (block_stall),
        .block        (block),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lucifer_block_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .block_valid  (block_valid),
        .block_stall  (block_stall),
        .block        (block),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[lucifer_block_cipher] ERROR");
            $finish;
        end
    end

    // The receiver runs its own stall pattern and takes long hold-offs when asked.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(RX_TOGGLE, RX_FREE));
                mode_left = $urandom_range(100, 10);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:  result_stall <= 1'b0;
                RX_LIGHT: result_stall <= ($urandom_range(3, 0) == 0);
                RX_HEAVY: result_stall <= ($urandom_range(3, 0) != 0);
                default:  result_stall <= ~result_stall;
            endcase
        end
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(15, 0))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic offer(input logic [63:0] low, input logic [63:0] high, input logic dec);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            if (gap_max > 0)
            begin
                block_valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(negedge clk);
            end
        end
        burst_left--;
        block_valid      <= 1'b1;
        block.block_low  <= low;
        block.block_high <= high;
        block.decrypt    <= dec;
        do @(posedge clk); while (block_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        block_valid <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_key(input logic [63:0] low, input logic [63:0] high);
        drain();
        write_cfg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_KEY_HIGH + 1)), rand_word());
        write_cfg(CFG_KEY_LOW, low);
        write_cfg(CFG_KEY_HIGH, high);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_set(input logic [63:0] low, input logic [63:0] high);
        offer('0, '0, 1'b0);
        offer('0, '0, 1'b1);
        offer('1, '1, 1'b0);
        offer('1, '1, 1'b1);
        offer(low, high, 1'($urandom_range(1, 0)));
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_set(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        load_key('1, '1);
        directed_set(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        load_key('1, '0);
        directed_set(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
        load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        directed_set(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                2:       load_key('0, '0);
                3:       load_key('1, '1);
                4:       load_key(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
                default: load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            gap_max = (p == 3) ? 0 : $urandom_range(12, 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == 30)
                begin
                    holds_asked++;
                    gap_max = 0;
                end
                if (p == 1 && n == 75)
                begin
                    gap_max = 8;
                    drain();
                end
                offer(rand_word(), rand_word(), 1'($urandom_range(1, 0)));
            end
        end

        drain();
        if (fail_count == 0)
        begin
            $display("[lucifer_block_cipher] OK");
        end
        else
        begin
            $display("[lucifer_block_cipher] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/luc_pkg.sv
sv/luc_round.sv
sv/lucifer_block_cipher.sv
tb/lucifer_block_checker.sv
tb/testbench.sv
